// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the job store.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== src/tcpjs_pkg.sv =====
// Package of the three-class priority job store: request, class and status
// codes and the command/status structs between controller and datapath.
`default_nettype none
package tcpjs_pkg;

    localparam logic       REQ_PUSH   = 1'b0;
    localparam logic       REQ_POP    = 1'b1;

    localparam logic [1:0] CLASS_HIGH = 2'd0;
    localparam logic [1:0] CLASS_MID  = 2'd1;
    localparam logic [1:0] CLASS_LOW  = 2'd2;
    localparam logic [1:0] CLASS_BAD  = 2'd3;

    localparam logic [2:0] ST_PUSHED  = 3'd0;
    localparam logic [2:0] ST_POPPED  = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BAD     = 3'd4;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_read;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== src/three_class_priority_job_store_unit.sv =====
// Top level of the three-class priority job store.
// Depends on tcpjs_pkg, tcpjs_ctrl and tcpjs_datapath.
//
// Usage:
//   Request channel: drive i_req_type, i_job_class, i_job_number and raise
//   start; the transaction is taken at a clock edge where start is high and
//   busy is low. busy stays high until the result has been registered.
//   Result channel: o_valid is high for exactly one cycle with
//   o_served_job, o_served_class, o_status and o_any_waiting. The receiver
//   cannot stall; the result must be taken in that cycle.
//   A push or a pop that finds every class empty goes from the request
//   register to the result register; a pop that serves a job also passes
//   through the registered read port of its class RAM, as the job comes out.
//   No new transaction is taken before the result has been registered;
//   a new transaction may be taken in the same cycle that the previous
//   result is shown.
//   Reset (i_rst_n low, synchronous) clears the class counts, the state
//   machine and o_valid. RAM contents are not cleared; no clearing pass is
//   needed since entries are read only below the class count.
`default_nettype none
module three_class_priority_job_store_unit #(
    parameter int CLASS_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_req_type,
    input  wire logic [1:0]  i_job_class,
    input  wire logic [15:0] i_job_number,
    output logic             o_valid,
    output logic      [15:0] o_served_job,
    output logic      [1:0]  o_served_class,
    output logic      [2:0]  o_status,
    output logic             o_any_waiting
);

    tcpjs_pkg::t_dp_cmd  cmd;
    tcpjs_pkg::t_dp_stat stat;

    tcpjs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    tcpjs_datapath #(
        .CLASS_DEPTH (CLASS_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (i_req_type),
        .i_job_class    (i_job_class),
        .i_job_number   (i_job_number),
        .o_valid        (o_valid),
        .o_served_job   (o_served_job),
        .o_served_class (o_served_class),
        .o_status       (o_status),
        .o_any_waiting  (o_any_waiting)
    );

endmodule
`default_nettype wire

// ===== src/tcpjs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tcpjs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/tcpjs_ctrl.sv =====
// Controller of the job store: sequences load, execute and finish steps.
// Depends on tcpjs_pkg.
`default_nettype none
module tcpjs_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire tcpjs_pkg::t_dp_stat i_stat,
    output logic                     o_busy,
    output tcpjs_pkg::t_dp_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_read ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== src/tcpjs_datapath.sv =====
// Datapath of the job store: request register, class counts, three class
// RAMs and the result register. Depends on tcpjs_pkg and tcpjs_ram.
`default_nettype none
module tcpjs_datapath #(
    parameter int CLASS_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tcpjs_pkg::t_dp_cmd  i_cmd,
    output tcpjs_pkg::t_dp_stat      o_stat,
    input  wire logic                i_req_type,
    input  wire logic [1:0]          i_job_class,
    input  wire logic [15:0]         i_job_number,
    output logic                     o_valid,
    output logic      [15:0]         o_served_job,
    output logic      [1:0]          o_served_class,
    output logic      [2:0]          o_status,
    output logic                     o_any_waiting
);

    localparam int AW = $clog2(CLASS_DEPTH);
    localparam int CW = $clog2(CLASS_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(CLASS_DEPTH);

    logic          r_req;
    logic [1:0]    r_cls;
    logic [15:0]   r_job;
    logic [CW-1:0] r_cnt [3];
    logic [CW-1:0] n_cnt [3];
    logic [1:0]    r_hit;
    logic [1:0]    n_hit;
    logic [2:0]    n_status;
    logic          n_any;
    logic          need_read;
    logic [2:0]    we;
    logic [AW-1:0] addr;
    logic [15:0]   rdata [3];
    logic [15:0]   sel_rdata;
    logic          r_valid;
    logic [15:0]   r_served_job;
    logic [1:0]    r_served_class;
    logic [2:0]    r_status;
    logic          r_any_waiting;

    always_comb begin
        logic          found;
        logic [CW-1:0] dec;
        found     = 1'b0;
        dec       = '0;
        n_cnt     = r_cnt;
        n_hit     = tcpjs_pkg::CLASS_HIGH;
        n_status  = tcpjs_pkg::ST_EMPTY;
        need_read = 1'b0;
        we        = '0;
        addr      = '0;
        if (r_req == tcpjs_pkg::REQ_PUSH) begin
            n_status = tcpjs_pkg::ST_BAD;
            for (int k = 0; k < 3; k++) begin
                if (r_cls == 2'(k)) begin
                    if (r_cnt[k] == CNT_FULL) begin
                        n_status = tcpjs_pkg::ST_FULL;
                    end else begin
                        n_status = tcpjs_pkg::ST_PUSHED;
                        we[k]    = 1'b1;
                        addr     = r_cnt[k][AW-1:0];
                        n_cnt[k] = r_cnt[k] + 1'b1;
                    end
                end
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (!found && r_cnt[k] != '0) begin
                    found     = 1'b1;
                    dec       = r_cnt[k] - 1'b1;
                    n_hit     = 2'(k);
                    addr      = dec[AW-1:0];
                    n_cnt[k]  = dec;
                    n_status  = tcpjs_pkg::ST_POPPED;
                    need_read = 1'b1;
                end
            end
        end
        n_any = (n_cnt[0] != '0) || (n_cnt[1] != '0) || (n_cnt[2] != '0);
    end

    assign o_stat.need_read = need_read;

    for (genvar g = 0; g < 3; g++) begin : g_store
        tcpjs_ram #(
            .WIDTH (16),
            .DEPTH (CLASS_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[g] & i_cmd.exec),
            .i_waddr (addr),
            .i_wdata (r_job),
            .i_raddr (addr),
            .o_rdata (rdata[g])
        );
    end

    always_comb begin
        unique case (r_hit)
            tcpjs_pkg::CLASS_HIGH: sel_rdata = rdata[0];
            tcpjs_pkg::CLASS_MID:  sel_rdata = rdata[1];
            default:               sel_rdata = rdata[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_cnt[2] <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_cnt <= n_cnt;
            end
            r_valid <= (i_cmd.exec & ~need_read) | i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_cls <= i_job_class;
            r_job <= i_job_number;
        end
        if (i_cmd.exec) begin
            r_hit <= n_hit;
        end
        if (i_cmd.exec && !need_read) begin
            r_served_job   <= '0;
            r_served_class <= tcpjs_pkg::CLASS_HIGH;
            r_status       <= n_status;
            r_any_waiting  <= n_any;
        end else if (i_cmd.finish) begin
            r_served_job   <= sel_rdata;
            r_served_class <= r_hit;
            r_status       <= tcpjs_pkg::ST_POPPED;
            r_any_waiting  <= (r_cnt[0] != '0) || (r_cnt[1] != '0) || (r_cnt[2] != '0);
        end
    end

    assign o_valid        = r_valid;
    assign o_served_job   = r_served_job;
    assign o_served_class = r_served_class;
    assign o_status       = r_status;
    assign o_any_waiting  = r_any_waiting;

endmodule
`default_nettype wire

// ===== src/tcpjs_checker.sv =====
// Port-level checker of the job store and its bind to the top level.
// Depends on tcpjs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tcpjs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [15:0] o_served_job,
    input wire logic [1:0]  o_served_class,
    input wire logic [2:0]  o_status,
    input wire logic        o_any_waiting
);

    wire logic w_popped;
    wire logic w_no_serve;

    assign w_popped   = o_valid && (o_status == tcpjs_pkg::ST_POPPED);
    assign w_no_serve = (o_served_job == 16'd0) && (o_served_class == tcpjs_pkg::CLASS_HIGH);

    `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `ASSERT_NEXT(a_single_pulse, o_valid, !o_valid)
    `ASSERT_SAME(a_no_serve_zero, o_valid && !w_popped, w_no_serve)
    `ASSERT_SAME(a_empty_idle, o_valid && o_status == tcpjs_pkg::ST_EMPTY, !o_any_waiting)
    `ASSERT_SAME(a_served_class, w_popped, o_served_class != tcpjs_pkg::CLASS_BAD)

endmodule

bind three_class_priority_job_store_unit tcpjs_checker u_tcpjs_checker (.*);
`default_nettype wire
